// ----- rtl/mbe_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time block.
package mbe_pkg;

  localparam int MBE_FRACTION_BITS = 24;
  localparam int POINT_W           = 28;
  localparam int COUNT_W           = 16;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd1000;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } mbe_state_t;

  // Sequencer commands to the iteration datapath.
  typedef struct packed {
    logic load;  // take a new point and form the squares of c
    logic step;  // advance z by one iteration
  } mbe_ctrl_t;

endpackage

// ----- rtl/mbe_iter_unit.sv -----
// Iteration datapath: holds c and the products of z, advances z by one step per cycle while step is asserted.
module mbe_iter_unit import mbe_pkg::*; #(
  parameter int FRACTION_BITS = MBE_FRACTION_BITS
) (
  input  logic                      clk,
  input  mbe_ctrl_t                 ctrl_i,
  input  logic signed [POINT_W-1:0] point_real_i,
  input  logic signed [POINT_W-1:0] point_imag_i,
  output logic                      escaped_o
);

  // While z is inside radius 2, the next z stays below 12 in magnitude; c itself
  // may use the full input width.
  localparam int ZW = (FRACTION_BITS + 5 > POINT_W + 1) ? FRACTION_BITS + 5 : POINT_W + 1;
  localparam int PW = 2 * ZW;
  localparam logic [PW-1:0] FOUR = PW'(1) << (2 * FRACTION_BITS + 2);

  logic signed [ZW-1:0] x0_r, y0_r, x0_nxt, y0_nxt;
  logic signed [PW-1:0] x2_r, y2_r, xy_r, x2_nxt, y2_nxt, xy_nxt;

  logic        [PW-1:0] mag_sum;
  logic signed [PW-1:0] diff, diff_sh, xy_sh;
  logic signed [ZW-1:0] nx, ny, mul_a, mul_b;

  always_comb begin
    x0_nxt = {{(ZW - POINT_W){point_real_i[POINT_W-1]}}, point_real_i};
    y0_nxt = {{(ZW - POINT_W){point_imag_i[POINT_W-1]}}, point_imag_i};

    // Both squares are nonnegative, so their top bits are zero and the sum fits.
    mag_sum   = {1'b0, x2_r[PW-2:0]} + {1'b0, y2_r[PW-2:0]};
    escaped_o = (mag_sum >= FOUR);

    diff    = x2_r - y2_r;
    diff_sh = diff >>> FRACTION_BITS;
    // Doubling the cross product folds into a shift one place shorter.
    xy_sh   = xy_r >>> (FRACTION_BITS - 1);
    nx      = diff_sh[ZW-1:0] + x0_r;
    ny      = xy_sh[ZW-1:0] + y0_r;

    mul_a  = ctrl_i.load ? x0_nxt : nx;
    mul_b  = ctrl_i.load ? y0_nxt : ny;
    x2_nxt = mul_a * mul_a;
    y2_nxt = mul_b * mul_b;
    xy_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
    end
    if (ctrl_i.load || ctrl_i.step) begin
      x2_r <= x2_nxt;
      y2_r <= y2_nxt;
      xy_r <= xy_nxt;
    end
  end

endmodule

// ----- rtl/mbe_seq.sv -----
// Sequencer: accepts a point, counts iterations and holds the result beat.
module mbe_seq import mbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [COUNT_W-1:0] cfg_limit_i,
  input  logic               escaped_i,
  output mbe_ctrl_t          ctrl_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [COUNT_W-1:0] out_tdata
);

  mbe_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ctrl_o        = '0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl_o.load = 1'b1;
          count_nxt   = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!escaped_i && (count_r < cfg_limit_i)) begin
          ctrl_o.step = 1'b1;
          count_nxt   = count_r + 1'b1;
        end else if (!out_valid_r || out_tready) begin
          // The datapath holds still until the result register frees up.
          out_valid_nxt = 1'b1;
          out_data_nxt  = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/mandelbrot_escape_iteration_top.sv -----
// Top level of the Mandelbrot escape-time counter.
//
// A point c arrives as one beat on the in_ stream; the escape count leaves as
// one beat on the out_ stream. cfg_wr_en with cfg_wr_data sets the iteration
// limit (reset value 1000); the user must write it only while the block is
// idle, which the block itself does not enforce. The accepting edge loads c
// and forms its squares. Each following cycle checks |z|^2 < 4 against the
// registered products and, while the point has not escaped and the count
// is below the limit, advances z by one iteration through the shared
// multiply/add datapath. The result is registered once the point escapes or
// reaches the limit, and only then can the next point be accepted; the escape
// loop through the three product registers carries one point at a time.
// in_tready is high only while no point is in flight. A finished result
// waits in the output register; if the receiver stalls while a second point
// finishes, that point holds its state until the register frees up.
// Reset clears the sequencer, drops out_tvalid and restores the limit.
module mandelbrot_escape_iteration_top import mbe_pkg::*; #(
  parameter int FRACTION_BITS = MBE_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [55:0]        in_tdata,    // point_real [27:0], point_imag [55:28]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [COUNT_W-1:0] out_tdata,   // escape_count [15:0]
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  logic [COUNT_W-1:0] limit_r;
  mbe_ctrl_t          ctrl;
  logic               escaped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  mbe_iter_unit #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_iter (
    .clk          (clk),
    .ctrl_i       (ctrl),
    .point_real_i (in_tdata[POINT_W-1:0]),
    .point_imag_i (in_tdata[2*POINT_W-1:POINT_W]),
    .escaped_o    (escaped)
  );

  mbe_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cfg_limit_i (limit_r),
    .escaped_i   (escaped),
    .ctrl_o      (ctrl),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Loading a point and stepping z never happen in the same cycle.
  a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.load && ctrl.step))
    else $error("load and step asserted together");

  // z only advances while the point is still inside radius 2.
  a_step_inside: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |-> !escaped)
    else $error("iteration stepped after escape");

  // Once a point is taken, no second point is taken in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a point is in flight");

endmodule
